// ===== design/prc_pkg.sv =====
// progress ring classifier package: shared constants, codes, types and the arctangent table
// no dependencies; used by every module of the classifier
package prc_pkg;

   // angle unit sizing
   localparam int CORDIC_STEPS = 30;
   localparam int PRESCALE     = 20;
   localparam int TURN_BITS    = 32;
   localparam int QUARTER_BITS = 30;
   localparam int ACC_BITS     = 33;

   // fill level
   localparam int FILL_BITS = 14;
   localparam logic [FILL_BITS-1:0] FULL_LEVEL = 14'd10000;

   // outer radius
   localparam int RADIUS_BITS = 8;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_X     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_Y     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUTER_RADIUS = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILL_LEVEL   = 2'd3;

   // shade codes
   localparam logic [1:0] SHADE_NONE     = 2'd0;
   localparam logic [1:0] SHADE_FILLED   = 2'd1;
   localparam logic [1:0] SHADE_UNFILLED = 2'd2;

   // quadrants, clockwise from 12 o'clock
   localparam logic [1:0] QUAD_NE = 2'd0;
   localparam logic [1:0] QUAD_SE = 2'd1;
   localparam logic [1:0] QUAD_SW = 2'd2;
   localparam logic [1:0] QUAD_NW = 2'd3;

   // what the back end must do with a pixel
   typedef enum logic [1:0] {
      CLS_OUT,
      CLS_FULL,
      CLS_EMPTY,
      CLS_ANGLE
   } prc_cls_type;

   // side information travelling with a pixel down the angle pipeline
   typedef struct packed {
      prc_cls_type cls;
      logic [1:0]  quad;
      logic        zero_b;
   } prc_side_type;

   // arctangent of 2^-step in units of 2^-32 turn
   function automatic logic [TURN_BITS-1:0] cordic_atan(input logic [4:0] step);
      logic [TURN_BITS-1:0] val;
      unique case (step)
         5'd0:    val = 32'd536870912;
         5'd1:    val = 32'd316933406;
         5'd2:    val = 32'd167458907;
         5'd3:    val = 32'd85004756;
         5'd4:    val = 32'd42667331;
         5'd5:    val = 32'd21354465;
         5'd6:    val = 32'd10679838;
         5'd7:    val = 32'd5340245;
         5'd8:    val = 32'd2670163;
         5'd9:    val = 32'd1335087;
         5'd10:   val = 32'd667544;
         5'd11:   val = 32'd333772;
         5'd12:   val = 32'd166886;
         5'd13:   val = 32'd83443;
         5'd14:   val = 32'd41722;
         5'd15:   val = 32'd20861;
         5'd16:   val = 32'd10430;
         5'd17:   val = 32'd5215;
         5'd18:   val = 32'd2608;
         5'd19:   val = 32'd1304;
         5'd20:   val = 32'd652;
         5'd21:   val = 32'd326;
         5'd22:   val = 32'd163;
         5'd23:   val = 32'd81;
         5'd24:   val = 32'd41;
         5'd25:   val = 32'd20;
         5'd26:   val = 32'd10;
         5'd27:   val = 32'd5;
         5'd28:   val = 32'd3;
         5'd29:   val = 32'd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== design/prc_front.sv =====
// progress ring classifier front end: input register, offsets, squares, band test, quadrant fold
// depends on prc_pkg; feeds the first stage of the angle pipeline
module prc_front #(
   parameter int COORD_BITS = 11,
   parameter int BAND_WIDTH = 7
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    accept,
   input  logic [COORD_BITS-1:0]                   pixel_x,
   input  logic [COORD_BITS-1:0]                   pixel_y,
   input  logic [COORD_BITS-1:0]                   center_x,
   input  logic [COORD_BITS-1:0]                   center_y,
   input  logic [prc_pkg::RADIUS_BITS-1:0]         outer_radius,
   input  logic [prc_pkg::FILL_BITS-1:0]           fill_level,
   output logic                                    valid_o,
   output logic signed [COORD_BITS+prc_pkg::PRESCALE+2:0] x_o,
   output logic signed [COORD_BITS+prc_pkg::PRESCALE+2:0] y_o,
   output prc_pkg::prc_side_type                   side_o
);

   localparam int XW = COORD_BITS + prc_pkg::PRESCALE + 3;
   localparam int SW = 2 * COORD_BITS;
   localparam int RW = prc_pkg::RADIUS_BITS;

   // derived band limits
   logic [RW-1:0]   band_w;
   logic [RW-1:0]   inner_r;
   logic [2*RW-1:0] outer_sq_ff, outer_sq_in;
   logic [2*RW-1:0] inner_sq_ff, inner_sq_in;

   // stage 0: input register
   logic                  s0_valid_ff, s0_valid_in;
   logic [COORD_BITS-1:0] s0_px_ff, s0_px_in;
   logic [COORD_BITS-1:0] s0_py_ff, s0_py_in;

   // stage 1: offset magnitudes and signs
   logic                  s1_valid_ff, s1_valid_in;
   logic [COORD_BITS-1:0] s1_mx_ff, s1_mx_in;
   logic [COORD_BITS-1:0] s1_my_ff, s1_my_in;
   logic                  s1_xneg_ff, s1_xneg_in;
   logic                  s1_xzero_ff, s1_xzero_in;
   logic                  s1_yneg_ff, s1_yneg_in;
   logic                  s1_yzero_ff, s1_yzero_in;

   // stage 2: squares and folded vector
   logic                  s2_valid_ff, s2_valid_in;
   logic [SW-1:0]         s2_sqx_ff, s2_sqx_in;
   logic [SW-1:0]         s2_sqy_ff, s2_sqy_in;
   logic [COORD_BITS-1:0] s2_a_ff, s2_a_in;
   logic [COORD_BITS-1:0] s2_b_ff, s2_b_in;
   logic [1:0]            s2_quad_ff, s2_quad_in;
   logic                  x_pos;
   logic                  y_pos;

   // stage 3: band test and angle unit load
   logic                  s3_valid_ff, s3_valid_in;
   logic signed [XW-1:0]  s3_x_ff, s3_x_in;
   logic signed [XW-1:0]  s3_y_ff, s3_y_in;
   prc_pkg::prc_side_type s3_side_ff, s3_side_in;
   logic [SW:0]           d2;
   logic                  in_band;

   // band limits follow the radius register
   always_comb begin
      band_w      = (outer_radius < RW'(BAND_WIDTH)) ? outer_radius : RW'(BAND_WIDTH);
      inner_r     = outer_radius - band_w;
      outer_sq_in = (2*RW)'(outer_radius) * (2*RW)'(outer_radius);
      inner_sq_in = (2*RW)'(inner_r) * (2*RW)'(inner_r);
   end

   // stage 0 next values
   always_comb begin
      s0_valid_in = accept;
      s0_px_in    = pixel_x;
      s0_py_in    = pixel_y;
   end

   // stage 1: pick the non-negative difference
   always_comb begin
      s1_valid_in = s0_valid_ff;
      s1_xneg_in  = center_x > s0_px_ff;
      s1_yneg_in  = center_y > s0_py_ff;
      s1_xzero_in = center_x == s0_px_ff;
      s1_yzero_in = center_y == s0_py_ff;
      s1_mx_in    = s1_xneg_in ? (center_x - s0_px_ff) : (s0_px_ff - center_x);
      s1_my_in    = s1_yneg_in ? (center_y - s0_py_ff) : (s0_py_ff - center_y);
   end

   // stage 2: squares, quadrant fold (north is minus dy, east is dx)
   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_sqx_in   = SW'(s1_mx_ff) * SW'(s1_mx_ff);
      s2_sqy_in   = SW'(s1_my_ff) * SW'(s1_my_ff);
      x_pos       = !s1_xneg_ff && !s1_xzero_ff;
      y_pos       = !s1_yneg_ff && !s1_yzero_ff;
      priority if (s1_yneg_ff && !s1_xneg_ff) begin
         s2_quad_in = prc_pkg::QUAD_NE;
         s2_a_in    = s1_my_ff;
         s2_b_in    = s1_mx_ff;
      end else if (!s1_yneg_ff && x_pos) begin
         s2_quad_in = prc_pkg::QUAD_SE;
         s2_a_in    = s1_mx_ff;
         s2_b_in    = s1_my_ff;
      end else if (y_pos && !x_pos) begin
         s2_quad_in = prc_pkg::QUAD_SW;
         s2_a_in    = s1_my_ff;
         s2_b_in    = s1_mx_ff;
      end else begin
         s2_quad_in = prc_pkg::QUAD_NW;
         s2_a_in    = s1_mx_ff;
         s2_b_in    = s1_my_ff;
      end
   end

   // stage 3: band test, shade class, scaled vector
   always_comb begin
      s3_valid_in = s2_valid_ff;
      d2          = {1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff};
      in_band     = (d2 <= (SW+1)'(outer_sq_ff)) && (d2 > (SW+1)'(inner_sq_ff));
      s3_side_in.quad   = s2_quad_ff;
      s3_side_in.zero_b = s2_b_ff == '0;
      priority if (!in_band) begin
         s3_side_in.cls = prc_pkg::CLS_OUT;
      end else if (fill_level >= prc_pkg::FULL_LEVEL) begin
         s3_side_in.cls = prc_pkg::CLS_FULL;
      end else if (fill_level == '0) begin
         s3_side_in.cls = prc_pkg::CLS_EMPTY;
      end else begin
         s3_side_in.cls = prc_pkg::CLS_ANGLE;
      end
      s3_x_in = signed'({3'b000, s2_a_ff, {prc_pkg::PRESCALE{1'b0}}});
      s3_y_in = signed'({3'b000, s2_b_ff, {prc_pkg::PRESCALE{1'b0}}});
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      outer_sq_ff <= outer_sq_in;
      inner_sq_ff <= inner_sq_in;
      s0_px_ff    <= s0_px_in;
      s0_py_ff    <= s0_py_in;
      s1_mx_ff    <= s1_mx_in;
      s1_my_ff    <= s1_my_in;
      s1_xneg_ff  <= s1_xneg_in;
      s1_xzero_ff <= s1_xzero_in;
      s1_yneg_ff  <= s1_yneg_in;
      s1_yzero_ff <= s1_yzero_in;
      s2_sqx_ff   <= s2_sqx_in;
      s2_sqy_ff   <= s2_sqy_in;
      s2_a_ff     <= s2_a_in;
      s2_b_ff     <= s2_b_in;
      s2_quad_ff  <= s2_quad_in;
      s3_x_ff     <= s3_x_in;
      s3_y_ff     <= s3_y_in;
      s3_side_ff  <= s3_side_in;
   end

   assign valid_o = s3_valid_ff;
   assign x_o     = s3_x_ff;
   assign y_o     = s3_y_ff;
   assign side_o  = s3_side_ff;

endmodule

// ===== design/prc_cordic_stage.sv =====
// progress ring classifier: one vectoring rotation of the angle pipeline, registered
// depends on prc_pkg for the arctangent table and accumulator width
module prc_cordic_stage #(
   parameter int STEP       = 0,
   parameter int COORD_BITS = 11
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          valid_i,
   input  logic signed [COORD_BITS+prc_pkg::PRESCALE+2:0] x_i,
   input  logic signed [COORD_BITS+prc_pkg::PRESCALE+2:0] y_i,
   input  logic signed [prc_pkg::ACC_BITS-1:0]           z_i,
   input  prc_pkg::prc_side_type                         side_i,
   output logic                                          valid_o,
   output logic signed [COORD_BITS+prc_pkg::PRESCALE+2:0] x_o,
   output logic signed [COORD_BITS+prc_pkg::PRESCALE+2:0] y_o,
   output logic signed [prc_pkg::ACC_BITS-1:0]           z_o,
   output prc_pkg::prc_side_type                         side_o
);

   localparam int XW = COORD_BITS + prc_pkg::PRESCALE + 3;

   logic                               valid_ff, valid_in;
   logic signed [XW-1:0]               x_ff, x_in;
   logic signed [XW-1:0]               y_ff, y_in;
   logic signed [prc_pkg::ACC_BITS-1:0] z_ff, z_in;
   prc_pkg::prc_side_type              side_ff, side_in;
   logic signed [XW-1:0]               x_sh;
   logic signed [XW-1:0]               y_sh;
   logic signed [prc_pkg::ACC_BITS-1:0] step_angle;
   logic                               y_pos;

   // rotate towards the x axis; arithmetic shift rounds toward minus infinity
   always_comb begin
      valid_in   = valid_i;
      side_in    = side_i;
      x_sh       = x_i >>> STEP;
      y_sh       = y_i >>> STEP;
      step_angle = signed'({1'b0, prc_pkg::cordic_atan(5'(STEP))});
      y_pos      = !y_i[XW-1] && (y_i != '0);
      if (y_pos) begin
         x_in = x_i + y_sh;
         y_in = y_i - x_sh;
         z_in = z_i + step_angle;
      end else begin
         x_in = x_i - y_sh;
         y_in = y_i + x_sh;
         z_in = z_i - step_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      side_ff <= side_in;
   end

   assign valid_o = valid_ff;
   assign x_o     = x_ff;
   assign y_o     = y_ff;
   assign z_o     = z_ff;
   assign side_o  = side_ff;

endmodule

// ===== design/prc_back.sv =====
// progress ring classifier back end: angle code, fill comparison and result register
// depends on prc_pkg; takes the last stage of the angle pipeline
module prc_back #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                valid_i,
   input  logic signed [prc_pkg::ACC_BITS-1:0] z_i,
   input  prc_pkg::prc_side_type               side_i,
   input  logic [prc_pkg::FILL_BITS-1:0]       fill_level,
   output logic                                valid_o,
   output logic [1:0]                          shade_o
);

   localparam int PW = ANGLE_BITS + prc_pkg::FILL_BITS;
   localparam int QB = prc_pkg::QUARTER_BITS;
   localparam int TB = prc_pkg::TURN_BITS;

   // stage e1: clamped quarter angle plus quadrant base
   logic                      e1_valid_ff, e1_valid_in;
   logic [ANGLE_BITS-1:0]     e1_code_ff, e1_code_in;
   prc_pkg::prc_cls_type      e1_cls_ff, e1_cls_in;
   logic [QB-1:0]             zc;
   logic [TB-1:0]             turn;
   logic                      z_neg;
   logic                      z_big;

   // stage e2: code times full level
   logic                      e2_valid_ff, e2_valid_in;
   logic [PW-1:0]             e2_prod_ff, e2_prod_in;
   prc_pkg::prc_cls_type      e2_cls_ff, e2_cls_in;

   // stage e3: result register
   logic                      e3_valid_ff, e3_valid_in;
   logic [1:0]                e3_shade_ff, e3_shade_in;
   logic [PW-1:0]             limit;

   // clamp to one quarter turn, a flat vector gives exactly zero
   always_comb begin
      e1_valid_in = valid_i;
      e1_cls_in   = side_i.cls;
      z_neg       = z_i[prc_pkg::ACC_BITS-1];
      z_big       = !z_neg && (z_i[prc_pkg::ACC_BITS-2:QB] != '0);
      priority if (side_i.zero_b || z_neg) begin
         zc = '0;
      end else if (z_big) begin
         zc = '1;
      end else begin
         zc = z_i[QB-1:0];
      end
      turn       = {side_i.quad, zc};
      e1_code_in = turn[TB-1 -: ANGLE_BITS];
   end

   // code <= floor(fill * 2^ANGLE_BITS / 10000) is code * 10000 <= fill * 2^ANGLE_BITS
   always_comb begin
      e2_valid_in = e1_valid_ff;
      e2_cls_in   = e1_cls_ff;
      e2_prod_in  = PW'(e1_code_ff) * PW'(prc_pkg::FULL_LEVEL);
   end

   always_comb begin
      e3_valid_in = e2_valid_ff;
      limit       = {fill_level, {ANGLE_BITS{1'b0}}};
      unique case (e2_cls_ff)
         prc_pkg::CLS_OUT:   e3_shade_in = prc_pkg::SHADE_NONE;
         prc_pkg::CLS_FULL:  e3_shade_in = prc_pkg::SHADE_FILLED;
         prc_pkg::CLS_EMPTY: e3_shade_in = prc_pkg::SHADE_UNFILLED;
         prc_pkg::CLS_ANGLE: begin
            e3_shade_in = (e2_prod_ff <= limit) ? prc_pkg::SHADE_FILLED
                                                : prc_pkg::SHADE_UNFILLED;
         end
         default:            e3_shade_in = prc_pkg::SHADE_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
         e2_valid_ff <= 1'b0;
         e3_valid_ff <= 1'b0;
      end else begin
         e1_valid_ff <= e1_valid_in;
         e2_valid_ff <= e2_valid_in;
         e3_valid_ff <= e3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e1_code_ff  <= e1_code_in;
      e1_cls_ff   <= e1_cls_in;
      e2_prod_ff  <= e2_prod_in;
      e2_cls_ff   <= e2_cls_in;
      e3_shade_ff <= e3_shade_in;
   end

   assign valid_o = e3_valid_ff;
   assign shade_o = e3_shade_ff;

endmodule

// ===== design/progress_ring_pixel_classifier_unit.sv =====
// progress ring classifier top level: configuration registers and the full pipeline
// depends on prc_pkg, prc_front, prc_cordic_stage and prc_back
//
//   channel  ports                          transfer when
//   ------   -----------------------------  ----------------------------
//   request  start, busy, req_pixel_x/y     start high, busy low
//   result   rsp_valid, rsp_shade           rsp_valid high (one cycle)
//   config   csr_valid, csr_ready,          csr_valid and csr_ready high
//            csr_index, csr_data
//
// one pixel per clock, sustained; each result follows its request transfer
// through four front stages, one stage per rotation of the 30-step
// angle pipeline, and three back stages
// busy is high only during reset, which flushes every pipeline stage
// results cannot be held off, so nothing in the pipeline ever waits
module progress_ring_pixel_classifier_unit #(
   parameter int BAND_WIDTH = 7,
   parameter int ANGLE_BITS = 16,
   parameter int COORD_BITS = 11
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [COORD_BITS-1:0]                req_pixel_x,
   input  logic [COORD_BITS-1:0]                req_pixel_y,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_shade,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [prc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [prc_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int XW    = COORD_BITS + prc_pkg::PRESCALE + 3;
   localparam int STEPS = prc_pkg::CORDIC_STEPS;
   localparam int LAT   = 4 + STEPS + 3;

   // configuration registers
   logic [COORD_BITS-1:0]           center_x_ff, center_x_in;
   logic [COORD_BITS-1:0]           center_y_ff, center_y_in;
   logic [prc_pkg::RADIUS_BITS-1:0] outer_radius_ff, outer_radius_in;
   logic [prc_pkg::FILL_BITS-1:0]   fill_level_ff, fill_level_in;
   logic [prc_pkg::FILL_BITS-1:0]   fill_wr;
   logic                            csr_write;
   logic                            accept;

   // angle pipeline chain
   logic                                c_valid [STEPS+1];
   logic signed [XW-1:0]                c_x     [STEPS+1];
   logic signed [XW-1:0]                c_y     [STEPS+1];
   logic signed [prc_pkg::ACC_BITS-1:0] c_z     [STEPS+1];
   prc_pkg::prc_side_type               c_side  [STEPS+1];

   assign busy      = reset;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // register writes, fill level clamped to full
   always_comb begin
      center_x_in     = center_x_ff;
      center_y_in     = center_y_ff;
      outer_radius_in = outer_radius_ff;
      fill_level_in   = fill_level_ff;
      fill_wr         = csr_data[prc_pkg::FILL_BITS-1:0];
      if (csr_write) begin
         unique case (csr_index)
            prc_pkg::CSR_CENTER_X:     center_x_in = csr_data[COORD_BITS-1:0];
            prc_pkg::CSR_CENTER_Y:     center_y_in = csr_data[COORD_BITS-1:0];
            prc_pkg::CSR_OUTER_RADIUS: outer_radius_in = csr_data[prc_pkg::RADIUS_BITS-1:0];
            prc_pkg::CSR_FILL_LEVEL: begin
               fill_level_in = (fill_wr > prc_pkg::FULL_LEVEL) ? prc_pkg::FULL_LEVEL : fill_wr;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         outer_radius_ff <= '0;
         fill_level_ff   <= '0;
      end else begin
         center_x_ff     <= center_x_in;
         center_y_ff     <= center_y_in;
         outer_radius_ff <= outer_radius_in;
         fill_level_ff   <= fill_level_in;
      end
   end

   // front end: offsets, band test, quadrant fold
   prc_front #(
      .COORD_BITS (COORD_BITS),
      .BAND_WIDTH (BAND_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .pixel_x      (req_pixel_x),
      .pixel_y      (req_pixel_y),
      .center_x     (center_x_ff),
      .center_y     (center_y_ff),
      .outer_radius (outer_radius_ff),
      .fill_level   (fill_level_ff),
      .valid_o      (c_valid[0]),
      .x_o          (c_x[0]),
      .y_o          (c_y[0]),
      .side_o       (c_side[0])
   );

   assign c_z[0] = '0;

   // angle pipeline, one rotation per stage
   for (genvar i = 0; i < STEPS; i++) begin : g_cordic
      prc_cordic_stage #(
         .STEP       (i),
         .COORD_BITS (COORD_BITS)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .valid_i (c_valid[i]),
         .x_i     (c_x[i]),
         .y_i     (c_y[i]),
         .z_i     (c_z[i]),
         .side_i  (c_side[i]),
         .valid_o (c_valid[i+1]),
         .x_o     (c_x[i+1]),
         .y_o     (c_y[i+1]),
         .z_o     (c_z[i+1]),
         .side_o  (c_side[i+1])
      );
   end

   // back end: angle code against fill limit
   prc_back #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .valid_i    (c_valid[STEPS]),
      .z_i        (c_z[STEPS]),
      .side_i     (c_side[STEPS]),
      .fill_level (fill_level_ff),
      .valid_o    (rsp_valid),
      .shade_o    (rsp_shade)
   );

`ifndef SYNTH
   // every request transfer yields exactly one result, a fixed latency later
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("request transfer without result");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("result without request transfer");

   // only the three defined shades leave the block
   a_shade_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_shade == prc_pkg::SHADE_NONE ||
                     rsp_shade == prc_pkg::SHADE_FILLED ||
                     rsp_shade == prc_pkg::SHADE_UNFILLED))
      else $error("illegal shade code");

   // stored fill level never exceeds full
   a_fill_clamped: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_index == prc_pkg::CSR_FILL_LEVEL |=>
         fill_level_ff <= prc_pkg::FULL_LEVEL)
      else $error("fill level above full");
`endif

endmodule
